[rtl/rvc_pkg.sv]
package rvc_pkg;

  localparam int unsigned MaxLines = 1024;
  localparam int unsigned WordBits = 32;

  typedef enum logic [4:0] {
    ClsKeep    = 5'd0,
    ClsAdd     = 5'd1,
    ClsMv      = 5'd2,
    ClsJr      = 5'd3,
    ClsJalr    = 5'd4,
    ClsLi      = 5'd5,
    ClsLui     = 5'd6,
    ClsAddi    = 5'd7,
    ClsSlli    = 5'd8,
    ClsLw      = 5'd9,
    ClsSw      = 5'd10,
    ClsAnd     = 5'd11,
    ClsOr      = 5'd12,
    ClsXor     = 5'd13,
    ClsSub     = 5'd14,
    ClsBeqz    = 5'd15,
    ClsBnez    = 5'd16,
    ClsSrli    = 5'd17,
    ClsSrai    = 5'd18,
    ClsAndi    = 5'd19,
    ClsJ       = 5'd20,
    ClsJal     = 5'd21,
    ClsBrKept  = 5'd22,
    ClsJalKept = 5'd23
  } cls_e;

  function automatic logic [2:0] creg(input logic [4:0] r);
    creg = 3'(r - 5'd8);
  endfunction

  function automatic logic [31:0] branch_off(input logic [31:0] w);
    branch_off = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
  endfunction

  function automatic logic [31:0] jump_off(input logic [31:0] w);
    jump_off = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
  endfunction

  function automatic logic is_walk(input logic [4:0] c);
    is_walk = (c == ClsBeqz) || (c == ClsBnez) || (c == ClsJ) || (c == ClsJal) ||
              (c == ClsBrKept) || (c == ClsJalKept);
  endfunction

  function automatic logic is_jump(input logic [4:0] c);
    is_jump = (c == ClsJ) || (c == ClsJal) || (c == ClsJalKept);
  endfunction

  function automatic logic [31:0] pack(input logic [4:0] cls, input logic [31:0] w,
                                       input logic [31:0] off);
    logic [4:0] rd, rs1, rs2;
    logic [15:0] h;
    begin
      rd  = w[11:7];
      rs1 = w[19:15];
      rs2 = w[24:20];
      h   = '0;
      pack = w;
      case (cls)
        ClsAdd:  h = {4'd9, rd, rs2, 2'd2};
        ClsMv:   h = {4'd8, rd, rs2, 2'd2};
        ClsJr:   h = {4'd8, rs1, 5'd0, 2'd2};
        ClsJalr: h = {4'd9, rs1, 5'd0, 2'd2};
        ClsLi:   h = {3'd2, w[25], rd, rs2, 2'd1};
        ClsLui:  h = {3'd3, w[17], rd, w[16:12], 2'd1};
        ClsAddi: h = {3'd0, w[25], rd, rs2, 2'd1};
        ClsSlli: h = {3'd0, 1'b0, rd, rs2, 2'd2};
        ClsLw:   h = {3'd2, w[25:23], creg(rs1), w[22], w[26], creg(rd), 2'd0};
        ClsSw:   h = {3'd6, w[25], w[11:10], creg(rs1), w[9], w[26], creg(rs2), 2'd0};
        ClsAnd:  h = {6'd35, creg(rd), 2'd3, creg(rs2), 2'd1};
        ClsOr:   h = {6'd35, creg(rd), 2'd2, creg(rs2), 2'd1};
        ClsXor:  h = {6'd35, creg(rd), 2'd1, creg(rs2), 2'd1};
        ClsSub:  h = {6'd35, creg(rd), 2'd0, creg(rs2), 2'd1};
        ClsBeqz, ClsBnez:
          h = {2'b11, (cls == ClsBnez), off[8], off[4:3], creg(rs1), off[7:6], off[2:1],
               off[5], 2'd1};
        ClsSrli: h = {3'd4, 1'b0, 2'd0, creg(rd), rs2, 2'd1};
        ClsSrai: h = {3'd4, 1'b0, 2'd1, creg(rd), rs2, 2'd1};
        ClsAndi: h = {3'd4, w[25], 2'd2, creg(rd), rs2, 2'd1};
        ClsJ, ClsJal:
          h = {(cls == ClsJ) ? 3'd5 : 3'd1, off[11], off[4], off[9:8], off[10], off[6],
               off[7], off[3:1], off[5], 2'd1};
        default: h = '0;
      endcase
      case (cls)
        ClsKeep: pack = w;
        ClsBrKept: pack = {off[12], off[10:5], w[24:12], off[4:1], off[11], w[6:0]};
        ClsJalKept: pack = {off[20], off[10:1], off[11], off[19:12], w[11:0]};
        default: if (cls < ClsBrKept) pack = {16'd0, h};
      endcase
    end
  endfunction

endpackage

[rtl/rv32_to_rvc_compressor.sv]
// Repacks RV32I words into RVC form. Mode 0 beats write one size-map bit and
// return a zero beat. Beats without an offset pass from idle to the done state,
// which registers the result once the output register is free. Branches and
// jumps walk the size map one line per cycle. The map is a 1-bit RAM with one
// read or write port and a registered read. Entries never written read back as
// undefined. The next input beat is taken once the block is back in idle, even
// while a result still waits in the output register.
module rv32_to_rvc_compressor #(
  parameter int unsigned MAX_LINES = rvc_pkg::MaxLines
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // mode, line_index[10], line_is_short, instr_word[32], instr_class[5], pad
  input  logic [55:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_word[32], walk_error, pad
  output logic [39:0] m_axis_tdata
);

  localparam int unsigned AW = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;

  typedef enum logic [1:0] {SIdle, SWalk, SDrain, SDone} state_e;

  logic        mem_q [MAX_LINES];
  logic        rdata_q;
  state_e      state_q;
  logic [31:0] word_q, off_q;
  logic [4:0]  cls_q;
  logic [20:0] n_q;
  logic [32:0] cur_q;
  logic        err_q, neg_q, pend_q;
  logic [11:0] cnt_q;
  logic        ov_q;
  logic [31:0] ow_q;
  logic        oe_q;

  logic        in_fire;
  logic        in_mode, in_short;
  logic [9:0]  in_line;
  logic [31:0] in_word;
  logic [4:0]  in_cls;
  logic [31:0] in_off, mag;
  logic        rd_en;
  logic        cur_ok;
  logic [32:0] lim;
  logic [31:0] adj;

  assign in_mode  = s_axis_tdata[0];
  assign in_line  = s_axis_tdata[10:1];
  assign in_short = s_axis_tdata[11];
  assign in_word  = s_axis_tdata[43:12];
  assign in_cls   = s_axis_tdata[48:44];

  assign s_axis_tready = (state_q == SIdle);
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign in_off = rvc_pkg::is_jump(in_cls) ? rvc_pkg::jump_off(in_word)
                                           : rvc_pkg::branch_off(in_word);
  assign mag = in_off[31] ? 32'(-in_off) : in_off;
  assign lim = 33'(MAX_LINES);
  assign cur_ok = !cur_q[32] && (cur_q < lim);
  assign rd_en = (state_q == SWalk) && (n_q != '0) && cur_ok;
  assign adj = off_q[31] ? 32'(off_q + {19'd0, cnt_q, 1'b0})
                         : 32'(off_q - {19'd0, cnt_q, 1'b0});

  always_ff @(posedge clk_i) begin
    if (in_fire && !in_mode && ({22'd0, in_line} < 32'(MAX_LINES))) begin
      mem_q[AW'(in_line)] <= in_short;
    end
    if (rd_en) begin
      rdata_q <= mem_q[AW'(cur_q)];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      ov_q    <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      if (ov_q && m_axis_tready && (state_q != SDone)) ov_q <= 1'b0;
      case (state_q)
        SIdle: begin
          if (in_fire) begin
            word_q <= in_word;
            cls_q  <= in_cls;
            off_q  <= in_off;
            neg_q  <= in_off[31];
            n_q    <= 21'(mag >> 2);
            cur_q  <= in_off[31] ? 33'({23'd0, in_line} - 33'd1) : {23'd0, in_line};
            cnt_q  <= '0;
            err_q  <= 1'b0;
            pend_q <= 1'b0;
            if (!in_mode) begin
              cls_q <= rvc_pkg::ClsKeep;
              word_q <= '0;
              state_q <= SDone;
            end else if (rvc_pkg::is_walk(in_cls)) begin
              state_q <= SWalk;
            end else begin
              state_q <= SDone;
            end
          end
        end
        SWalk: begin
          if (pend_q) cnt_q <= cnt_q + {11'd0, rdata_q};
          pend_q <= rd_en;
          if (n_q == '0) begin
            state_q <= SDrain;
          end else begin
            if (!cur_ok) err_q <= 1'b1;
            n_q   <= n_q - 21'd1;
            cur_q <= neg_q ? cur_q - 33'd1 : cur_q + 33'd1;
          end
        end
        SDrain: begin
          if (pend_q) cnt_q <= cnt_q + {11'd0, rdata_q};
          pend_q <= 1'b0;
          state_q <= SDone;
        end
        SDone: begin
          if (!ov_q || m_axis_tready) begin
            ow_q <= rvc_pkg::pack(cls_q, word_q, adj);
            oe_q <= err_q;
            ov_q <= 1'b1;
            state_q <= SIdle;
          end
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {7'd0, oe_q, ow_q};

  a_rd_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |-> state_q == SWalk) else $error("map read outside walk");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q != SIdle) else $error("accept did not start work");
  a_out_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ov_q) |-> $past(state_q) == SDone) else $error("result without finish");

endmodule
